>>> hw/rtl/egpt_pkg.sv
`timescale 1ns / 1ps
// Package for the eroded grid point test: operation and register codes,
// reset values and the structs shared between the submodules. No dependencies.
package egpt_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_LEVEL  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_M = 4'd7;

	localparam logic [9:0]  RST_MAP_WIDTH   = 10'd512;
	localparam logic [9:0]  RST_MAP_HEIGHT  = 10'd512;
	localparam logic [3:0]  RST_KERNEL_SIZE = 4'd3;
	localparam logic [7:0]  RST_FREE_LEVEL  = 8'd205;
	localparam logic [31:0] RST_CELLS_PER_M = 32'd1310720;

	typedef struct packed {
		logic       valid;
		logic       start_of_map;
		logic [7:0] pixel;
	} load_req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] idx;
	} cell_t;

endpackage

>>> hw/rtl/egpt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module egpt_ram #(
	parameter int WIDTH = 512,
	parameter int DEPTH = 512
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/egpt_coord.sv
`timescale 1ns / 1ps
// World-to-cell conversion: registered 32x32 multiply by cells per metre,
// then truncation and range check. Depends on egpt_pkg.
module egpt_coord (
	input  logic                clk,
	input  logic                mul_en,
	input  logic [31:0]         mag,
	input  logic [31:0]         cells_per_metre,
	input  logic                neg,
	input  logic [31:0]         limit,
	output egpt_pkg::cell_t     cell_res
);

	logic [63:0] prod_s1;
	logic [31:0] whole;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= 64'(mag) * 64'(cells_per_metre);
		end
	end

	assign whole = prod_s1[63:32];

	always_comb begin
		cell_res.idx = whole;
		cell_res.ok  = !(neg && (whole != 32'd0)) && (whole < limit);
	end

endmodule

>>> hw/rtl/egpt_loader.sv
`timescale 1ns / 1ps
// Map loader: thresholds pixels, gathers one row and writes it bottom-up
// into the bitmap RAM. Depends on egpt_pkg.
module egpt_loader #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               restart,
	input  egpt_pkg::load_req_t                                req,
	input  logic                                               invert,
	input  logic [7:0]                                         free_level,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]                     w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]                    h,
	output logic                                               complete,
	output logic                                               ram_we,
	output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] ram_waddr,
	output logic [MAX_WIDTH-1:0]                               ram_wdata
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic                 complete_q;
	logic [MAX_WIDTH-1:0] accum_q;

	logic          done_eff;
	logic [CW-1:0] col_eff;
	logic [RW-1:0] row_eff;
	logic          do_wr;
	logic [7:0]    pix;
	logic          free_bit;
	logic          last_col;
	logic          last_row;

	always_comb begin
		done_eff  = req.start_of_map ? 1'b0 : complete_q;
		col_eff   = req.start_of_map ? '0 : col_q;
		row_eff   = req.start_of_map ? '0 : row_q;
		do_wr     = req.valid && !done_eff;
		pix       = invert ? ~req.pixel : req.pixel;
		free_bit  = pix > free_level;
		last_col  = 32'(col_eff) == (32'(w) - 32'd1);
		last_row  = 32'(row_eff) == (32'(h) - 32'd1);
		ram_wdata = accum_q;
		ram_wdata[col_eff] = free_bit;
		ram_we    = do_wr && last_col;
		ram_waddr = RW'(32'(h) - 32'd1 - 32'(row_eff));
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			accum_q[col_eff] <= free_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			complete_q <= 1'b0;
		end else if (restart) begin
			col_q      <= '0;
			row_q      <= '0;
			complete_q <= 1'b0;
		end else if (do_wr) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q      <= '0;
					complete_q <= 1'b1;
				end else begin
					row_q      <= RW'(32'(row_eff) + 32'd1);
					complete_q <= 1'b0;
				end
			end else begin
				col_q      <= CW'(32'(col_eff) + 32'd1);
				row_q      <= row_eff;
				complete_q <= 1'b0;
			end
		end
	end

	assign complete = complete_q;

endmodule

>>> hw/rtl/eroded_grid_point_test.sv
`timescale 1ns / 1ps
// Eroded grid point test. busy never rises for loads. A query passes through
// the MULX, MULY and CHKY states and shows done after CHKY when the map is
// incomplete or the point is off the map; else it goes on through WIN and
// ROW, which reads the clipped kernel window one bitmap row per cycle from
// the RAM. busy drops as done is shown. Reset clears control and map_ready;
// bitmap is not cleared and reads only rows written by a complete load.
module eroded_grid_point_test #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_KERNEL = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [7:0]                          pixel,
	input  logic                                start_of_map,
	input  logic signed [31:0]                  point_x,
	input  logic signed [31:0]                  point_y,
	input  logic                                cfg_we,
	input  logic [egpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [egpt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                done,
	output logic                                inside_res,
	output logic                                map_ready
);

	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);
	localparam int KB = $clog2(MAX_KERNEL + 1);
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MULX = 3'd1;
	localparam logic [2:0] S_MULY = 3'd2;
	localparam logic [2:0] S_CHKY = 3'd3;
	localparam logic [2:0] S_WIN  = 3'd4;
	localparam logic [2:0] S_ROW  = 3'd5;

	logic [9:0]         map_width_q;
	logic [9:0]         map_height_q;
	logic [3:0]         kernel_size_q;
	logic [7:0]         free_level_q;
	logic               invert_q;
	logic signed [31:0] origin_x_q;
	logic signed [31:0] origin_y_q;
	logic [31:0]        cells_per_metre_q;

	logic [2:0]           state_q;
	logic [31:0]          magx_q;
	logic [31:0]          magy_q;
	logic                 negx_q;
	logic                 negy_q;
	logic                 okx_q;
	logic [CW-1:0]        cx_q;
	logic [CW-1:0]        c0_q;
	logic [CW-1:0]        c1_q;
	logic [RW-1:0]        r0_q;
	logic [RW-1:0]        r1_q;
	logic [RW-1:0]        row_q;
	logic [MAX_WIDTH-1:0] mask_q;
	logic                 acc_q;
	logic                 done_q;
	logic                 inside_q;
	logic                 ready_q;

	logic [WB-1:0]        w_eff;
	logic [HB-1:0]        h_eff;
	logic [KB-1:0]        k_eff;
	logic                 accept;
	logic                 restart;
	egpt_pkg::load_req_t  load_req;
	logic                 complete;
	logic                 ram_we;
	logic [RW-1:0]        ram_waddr;
	logic [MAX_WIDTH-1:0] ram_wdata;
	logic [RW-1:0]        ram_raddr;
	logic [MAX_WIDTH-1:0] ram_rdata;
	logic [MAX_WIDTH-1:0] mask_n;
	logic                 row_ok;
	egpt_pkg::cell_t      cell_res;
	logic [31:0]          mul_a;
	logic                 cell_neg;
	logic [31:0]          cell_limit;
	logic signed [32:0]   dx;
	logic signed [32:0]   dy;
	logic [31:0]          cy32;
	logic [31:0]          a32;
	logic [31:0]          b32;
	logic [31:0]          r1w;
	logic [31:0]          c1w;
	logic [31:0]          r0w;
	logic [31:0]          c0w;

	always_comb begin
		w_eff = WB'((map_width_q == '0) ? 32'd1 :
			((32'(map_width_q) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(map_width_q)));
		h_eff = HB'((map_height_q == '0) ? 32'd1 :
			((32'(map_height_q) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(map_height_q)));
		k_eff = KB'((kernel_size_q == '0) ? 32'd1 :
			((32'(kernel_size_q) > 32'(MAX_KERNEL)) ? 32'(MAX_KERNEL) : 32'(kernel_size_q)));
	end

	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;
	assign restart  = cfg_we && (cfg_index == egpt_pkg::REG_MAP_WIDTH ||
		cfg_index == egpt_pkg::REG_MAP_HEIGHT);

	always_comb begin
		load_req.valid        = accept && (operation == egpt_pkg::OP_LOAD);
		load_req.start_of_map = start_of_map;
		load_req.pixel        = pixel;
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q       <= egpt_pkg::RST_MAP_WIDTH;
			map_height_q      <= egpt_pkg::RST_MAP_HEIGHT;
			kernel_size_q     <= egpt_pkg::RST_KERNEL_SIZE;
			free_level_q      <= egpt_pkg::RST_FREE_LEVEL;
			invert_q          <= 1'b0;
			origin_x_q        <= '0;
			origin_y_q        <= '0;
			cells_per_metre_q <= egpt_pkg::RST_CELLS_PER_M;
		end else if (cfg_we) begin
			unique case (cfg_index)
				egpt_pkg::REG_MAP_WIDTH:   map_width_q       <= cfg_data[9:0];
				egpt_pkg::REG_MAP_HEIGHT:  map_height_q      <= cfg_data[9:0];
				egpt_pkg::REG_KERNEL_SIZE: kernel_size_q     <= cfg_data[3:0];
				egpt_pkg::REG_FREE_LEVEL:  free_level_q      <= cfg_data[7:0];
				egpt_pkg::REG_INVERT:      invert_q          <= cfg_data[0];
				egpt_pkg::REG_ORIGIN_X:    origin_x_q        <= cfg_data;
				egpt_pkg::REG_ORIGIN_Y:    origin_y_q        <= cfg_data;
				egpt_pkg::REG_CELLS_PER_M: cells_per_metre_q <= cfg_data;
				default: ;
			endcase
		end
	end

	egpt_loader #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_loader (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.req        (load_req),
		.invert     (invert_q),
		.free_level (free_level_q),
		.w          (w_eff),
		.h          (h_eff),
		.complete   (complete),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	egpt_ram #(
		.WIDTH (MAX_WIDTH),
		.DEPTH (MAX_HEIGHT)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		mul_a      = (state_q == S_MULX) ? magx_q : magy_q;
		cell_neg   = (state_q == S_MULY) ? negx_q : negy_q;
		cell_limit = (state_q == S_MULY) ? 32'(w_eff) : 32'(h_eff);
	end

	egpt_coord u_coord (
		.clk             (clk),
		.mul_en          (state_q == S_MULX || state_q == S_MULY),
		.mag             (mul_a),
		.cells_per_metre (cells_per_metre_q),
		.neg             (cell_neg),
		.limit           (cell_limit),
		.cell_res        (cell_res)
	);

	always_comb begin
		dx   = 33'(point_x) - 33'(origin_x_q);
		dy   = 33'(point_y) - 33'(origin_y_q);
		cy32 = cell_res.idx;
		a32  = 32'(k_eff) >> 1;
		b32  = 32'(k_eff) - 32'd1 - a32;
		r0w  = (cy32 >= a32) ? cy32 - a32 : 32'd0;
		c0w  = (32'(cx_q) >= a32) ? 32'(cx_q) - a32 : 32'd0;
		r1w  = ((cy32 + b32) > (32'(h_eff) - 32'd1)) ? 32'(h_eff) - 32'd1 : cy32 + b32;
		c1w  = ((32'(cx_q) + b32) > (32'(w_eff) - 32'd1)) ?
			32'(w_eff) - 32'd1 : 32'(cx_q) + b32;
		ram_raddr = (state_q == S_WIN) ? r0_q : RW'(32'(row_q) + 32'd1);
		row_ok    = &(ram_rdata | ~mask_q);
		for (int i = 0; i < MAX_WIDTH; i++) begin
			mask_n[i] = (32'(c0_q) <= 32'(i)) && (32'(i) <= 32'(c1_q));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			negx_q <= dx[32];
			negy_q <= dy[32];
			magx_q <= dx[32] ? 32'(-dx) : dx[31:0];
			magy_q <= dy[32] ? 32'(-dy) : dy[31:0];
		end
		if (state_q == S_MULY) begin
			okx_q <= cell_res.ok;
			cx_q  <= CW'(cell_res.idx);
		end
		if (state_q == S_CHKY) begin
			r0_q <= RW'(r0w);
			r1_q <= RW'(r1w);
			c0_q <= CW'(c0w);
			c1_q <= CW'(c1w);
		end
		if (state_q == S_WIN) begin
			mask_q <= mask_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			row_q    <= '0;
			acc_q    <= 1'b0;
			done_q   <= 1'b0;
			inside_q <= 1'b0;
			ready_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation == egpt_pkg::OP_QUERY) begin
						state_q <= S_MULX;
					end
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_CHKY;
				S_CHKY: begin
					if (!complete || !okx_q || !cell_res.ok) begin
						done_q   <= 1'b1;
						inside_q <= 1'b0;
						ready_q  <= complete;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					row_q   <= r0_q;
					acc_q   <= 1'b1;
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (row_q == r1_q) begin
						done_q   <= 1'b1;
						inside_q <= acc_q && row_ok;
						ready_q  <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						acc_q <= acc_q && row_ok;
						row_q <= RW'(32'(row_q) + 32'd1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign inside_res = inside_q;
	assign map_ready  = ready_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_write_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (accept && operation == egpt_pkg::OP_LOAD))
		else $error("bitmap written outside a load request");

	a_inside_needs_map: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && inside_q) |-> ready_q)
		else $error("free reported without a complete map");

	a_row_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW) |-> (row_q >= r0_q && row_q <= r1_q))
		else $error("row scan left the window");

	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ram_we)
		else $error("bitmap written during a query");

endmodule

>>> tb/grid_answer_checker.sv
`timescale 1ns / 1ps
// Answer checker for the eroded grid point test: mirrors the registers and the
// one-bit map, predicts each query answer and compares it when done strobes.
// Depends on egpt_pkg for the operation and register codes and reset values.
module grid_answer_checker #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_KERNEL = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            operation,
	input  logic [7:0]                      pixel,
	input  logic                            start_of_map,
	input  logic [31:0]                     point_x,
	input  logic [31:0]                     point_y,
	input  logic                            cfg_we,
	input  logic [egpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [egpt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            done,
	input  logic                            inside_res,
	input  logic                            map_ready,
	output int                              answers_due,
	output int                              mismatches
);
	import egpt_pkg::*;

	typedef struct packed {
		logic free_hit;
		logic ready;
	} grid_answer_t;

	logic [9:0]   width_reg;
	logic [9:0]   height_reg;
	logic [3:0]   kernel_reg;
	logic [7:0]   level_reg;
	logic         invert_reg;
	logic [31:0]  origin_x_reg;
	logic [31:0]  origin_y_reg;
	logic [31:0]  cells_per_m_reg;
	bit           free_cells [MAX_WIDTH*MAX_HEIGHT];
	int           fill_row;
	int           fill_col;
	bit           map_held;
	grid_answer_t expected_answers [$];

	function automatic int clamp_dim(input int v, input int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void restart_fill();
		fill_row = 0;
		fill_col = 0;
		map_held = 1'b0;
	endfunction

	function automatic bit point_to_cell(input logic [31:0] p, input logic [31:0] o,
			input int limit, output int cell_no);
		logic signed [32:0] d;
		logic [32:0]        mag;
		logic [64:0]        prod;
		logic [32:0]        c;
		d = $signed({p[31], p}) - $signed({o[31], o});
		mag = d[32] ? 33'(-d) : 33'(d);
		prod = {32'd0, mag} * {33'd0, cells_per_m_reg};
		c = prod[64:32];
		if (d[32] && c != 33'd0) return 1'b0;
		if (c >= 33'(limit)) return 1'b0;
		cell_no = int'(c);
		return 1'b1;
	endfunction

	function automatic grid_answer_t predict_answer(input logic [31:0] px, input logic [31:0] py);
		grid_answer_t ans;
		int w, h, k, a, cx, cy, r0, r1, c0, c1;
		w = clamp_dim(int'(width_reg), MAX_WIDTH);
		h = clamp_dim(int'(height_reg), MAX_HEIGHT);
		ans.ready = map_held;
		ans.free_hit = 1'b0;
		if (map_held && point_to_cell(px, origin_x_reg, w, cx) &&
				point_to_cell(py, origin_y_reg, h, cy)) begin
			k = clamp_dim(int'(kernel_reg), MAX_KERNEL);
			a = k / 2;
			r0 = (cy >= a) ? cy - a : 0;
			r1 = cy + k - 1 - a;
			c0 = (cx >= a) ? cx - a : 0;
			c1 = cx + k - 1 - a;
			if (r1 > h - 1) r1 = h - 1;
			if (c1 > w - 1) c1 = w - 1;
			ans.free_hit = 1'b1;
			for (int r = r0; r <= r1; r++)
				for (int c = c0; c <= c1; c++)
					if (!free_cells[r*MAX_WIDTH + c]) ans.free_hit = 1'b0;
		end
		return ans;
	endfunction

	function automatic void store_pixel(input logic [7:0] p, input logic som);
		int         w, h;
		logic [7:0] v;
		w = clamp_dim(int'(width_reg), MAX_WIDTH);
		h = clamp_dim(int'(height_reg), MAX_HEIGHT);
		if (som) restart_fill();
		if (map_held) return;
		if (fill_row >= h || fill_col >= w) begin
			fill_row = 0;
			fill_col = 0;
		end
		v = invert_reg ? 8'(8'd255 - p) : p;
		free_cells[(h - 1 - fill_row)*MAX_WIDTH + fill_col] = (v > level_reg);
		fill_col++;
		if (fill_col >= w) begin
			fill_col = 0;
			fill_row++;
			if (fill_row >= h) begin
				fill_row = 0;
				map_held = 1'b1;
			end
		end
	endfunction

	function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MAP_WIDTH: begin
				width_reg = data[9:0];
				restart_fill();
			end
			REG_MAP_HEIGHT: begin
				height_reg = data[9:0];
				restart_fill();
			end
			REG_KERNEL_SIZE: kernel_reg = data[3:0];
			REG_FREE_LEVEL:  level_reg = data[7:0];
			REG_INVERT:      invert_reg = data[0];
			REG_ORIGIN_X:    origin_x_reg = data;
			REG_ORIGIN_Y:    origin_y_reg = data;
			REG_CELLS_PER_M: cells_per_m_reg = data;
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grid_answer_t want;
		if (!arst_n) begin
			width_reg = RST_MAP_WIDTH;
			height_reg = RST_MAP_HEIGHT;
			kernel_reg = RST_KERNEL_SIZE;
			level_reg = RST_FREE_LEVEL;
			invert_reg = 1'b0;
			origin_x_reg = 32'd0;
			origin_y_reg = 32'd0;
			cells_per_m_reg = RST_CELLS_PER_M;
			restart_fill();
			expected_answers.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: answer with none expected: inside_res=%0b map_ready=%0b",
						$time, inside_res, map_ready);
					mismatches++;
				end else begin
					want = expected_answers.pop_front();
					if (inside_res !== want.free_hit) begin
						$display("%0t: inside_res expected %0b actual %0b",
							$time, want.free_hit, inside_res);
						mismatches++;
					end
					if (map_ready !== want.ready) begin
						$display("%0t: map_ready expected %0b actual %0b",
							$time, want.ready, map_ready);
						mismatches++;
					end
				end
			end
			if (cfg_we) write_register(cfg_index, cfg_data);
			if (start && !busy) begin
				if (operation == OP_QUERY)
					expected_answers.push_back(predict_answer(point_x, point_y));
				else
					store_pixel(pixel, start_of_map);
			end
		end
		answers_due = expected_answers.size();
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the eroded grid point test bench: clock, reset, map loads, point queries
// and register writes. Depends on egpt_pkg, the block and grid_answer_checker.
module testbench;
	import egpt_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int ITEM_TARGET   = 1500;
	localparam int SIDE_MAX      = 512;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	logic                  busy;
	logic                  operation    = OP_LOAD;
	logic [7:0]            pixel        = 8'd0;
	logic                  start_of_map = 1'b0;
	logic [31:0]           point_x      = 32'd0;
	logic [31:0]           point_y      = 32'd0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  done;
	logic                  inside_res;
	logic                  map_ready;
	int                    answers_due;
	int                    mismatches;

	int          items_sent = 0;
	bit          steady     = 1'b0;
	bit          map_loaded = 1'b0;
	int          map_w      = SIDE_MAX;
	int          map_h      = SIDE_MAX;
	logic [7:0]  level_now  = RST_FREE_LEVEL;
	logic        invert_now = 1'b0;
	logic [31:0] ox_now     = 32'd0;
	logic [31:0] oy_now     = 32'd0;
	logic [31:0] cpm_now    = RST_CELLS_PER_M;

	eroded_grid_point_test dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .pixel(pixel), .start_of_map(start_of_map),
		.point_x(point_x), .point_y(point_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .inside_res(inside_res), .map_ready(map_ready)
	);

	grid_answer_checker watch (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .pixel(pixel), .start_of_map(start_of_map),
		.point_x(point_x), .point_y(point_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .inside_res(inside_res), .map_ready(map_ready),
		.answers_due(answers_due), .mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int clamp_side(input int v);
		if (v < 1) return 1;
		if (v > SIDE_MAX) return SIDE_MAX;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pad_upper(input logic [31:0] v, input int width);
		if ($urandom_range(0, 3) == 0) return v | ($urandom << width);
		return v;
	endfunction

	function automatic logic [7:0] make_pixel(input bit want_free);
		logic [7:0] v;
		if ($urandom_range(0, 63) == 0) return 8'($urandom);
		if (want_free && level_now != 8'hFF)
			v = 8'($urandom_range(int'(level_now) + 1, 255));
		else if (!want_free) v = 8'($urandom_range(0, int'(level_now)));
		else v = 8'hFF;
		return invert_now ? 8'(8'hFF - v) : v;
	endfunction

	function automatic logic [31:0] point_near(input int cell_no, input logic [31:0] origin);
		longint num, d, f;
		if (cpm_now == 32'd0) return $urandom;
		f = longint'($urandom);
		if (cell_no >= 0) num = (longint'(cell_no) <<< 32) + f;
		else if (cell_no == -1) num = -f;
		else num = -((longint'(1) <<< 32) + f);
		d = num / longint'(cpm_now);
		return origin + d[31:0];
	endfunction

	task automatic send_request(input logic op, input logic [7:0] pix, input logic som,
			input logic [31:0] px, input logic [31:0] py);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		pixel <= pix;
		start_of_map <= som;
		point_x <= px;
		point_y <= py;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_pixel(input logic [7:0] p, input logic som);
		send_request(OP_LOAD, p, som, $urandom, $urandom);
		items_sent++;
	endtask

	task automatic ask_point(input logic [31:0] px, input logic [31:0] py);
		send_request(OP_QUERY, 8'($urandom), 1'($urandom), px, py);
		items_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (answers_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_MAP_WIDTH: begin
				map_w = clamp_side(int'(data[9:0]));
				map_loaded = 1'b0;
			end
			REG_MAP_HEIGHT: begin
				map_h = clamp_side(int'(data[9:0]));
				map_loaded = 1'b0;
			end
			REG_FREE_LEVEL:  level_now = data[7:0];
			REG_INVERT:      invert_now = data[0];
			REG_ORIGIN_X:    ox_now = data;
			REG_ORIGIN_Y:    oy_now = data;
			REG_CELLS_PER_M: cpm_now = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_lookup();
		logic [31:0] v;
		int          r;
		write_reg(REG_KERNEL_SIZE, pad_upper($urandom_range(0, 15), 4));
		r = $urandom_range(0, 9);
		v = (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : $urandom_range(0, 240);
		write_reg(REG_FREE_LEVEL, pad_upper(v, 8));
		write_reg(REG_INVERT, pad_upper($urandom_range(0, 1), 1));
		for (int axis = 0; axis < 2; axis++) begin
			r = $urandom_range(0, 9);
			if (r == 0) v = 32'h8000_0000;
			else if (r == 1) v = 32'h7FFF_FFFF;
			else v = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			write_reg(axis == 0 ? REG_ORIGIN_X : REG_ORIGIN_Y, v);
		end
		case ($urandom_range(0, 11))
			0:       v = 32'd0;
			1:       v = 32'hFFFF_FFFF;
			2:       v = $urandom;
			3:       v = 32'h0000_8000;
			4:       v = 32'h0001_0000;
			5:       v = 32'h0001_0000 + $urandom_range(0, 16'hFFFF);
			default: v = ($urandom_range(1, 40) << 16) | $urandom_range(0, 16'hFFFF);
		endcase
		write_reg(REG_CELLS_PER_M, v);
		if ($urandom_range(0, 4) == 0)
			write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom);
	endtask

	task automatic fill_map(input int free_pct, input bit broken);
		int total, cut;
		total = map_w * map_h;
		if (broken) begin
			cut = $urandom_range(1, total);
			for (int n = 0; n < cut; n++)
				load_pixel(make_pixel($urandom_range(0, 99) < free_pct), n == 0);
			ask_point(point_near(0, ox_now), point_near(0, oy_now));
			ask_point($urandom, $urandom);
		end
		for (int n = 0; n < total; n++)
			load_pixel(make_pixel($urandom_range(0, 99) < free_pct), n == 0);
		map_loaded = 1'b1;
	endtask

	task automatic probe_map(input int count);
		int r, cx, cy;
		repeat (count) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				ask_point($urandom, $urandom);
			end else if (r == 1 && map_loaded) begin
				send_request(OP_LOAD, 8'($urandom), 1'b0, $urandom, $urandom);
			end else begin
				cx = $urandom_range(0, map_w + 3) - 2;
				cy = $urandom_range(0, map_h + 3) - 2;
				ask_point(point_near(cx, ox_now), point_near(cy, oy_now));
			end
		end
	endtask

	initial begin
		int          scenario;
		int          free_pct;
		logic [31:0] w_val, h_val;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ask_point(32'h8000_0000, 32'h7FFF_FFFF);
		ask_point(32'd0, 32'd0);
		settle();
		write_reg(REG_MAP_WIDTH, 32'd2);
		write_reg(REG_MAP_HEIGHT, 32'd2);
		write_reg(REG_KERNEL_SIZE, 32'd1);
		write_reg(REG_FREE_LEVEL, 32'd128);
		write_reg(REG_INVERT, 32'd0);
		write_reg(REG_ORIGIN_X, 32'd0);
		write_reg(REG_ORIGIN_Y, 32'd0);
		write_reg(REG_CELLS_PER_M, 32'h0001_0000);
		cfg_we <= 1'b0;
		load_pixel(8'd255, 1'b1);
		load_pixel(8'd0, 1'b0);
		load_pixel(8'd129, 1'b0);
		load_pixel(8'd128, 1'b0);
		send_request(OP_LOAD, 8'd0, 1'b0, 32'd0, 32'd0);
		ask_point(32'd0, 32'd0);
		ask_point(32'hFFFF_8000, 32'd0);
		ask_point(32'hFFFF_0000, 32'd0);
		ask_point(32'h0001_8000, 32'h0001_0000);
		ask_point(32'h0002_0000, 32'd0);
		ask_point(32'h7FFF_FFFF, 32'h8000_0000);
		settle();
		write_reg(REG_KERNEL_SIZE, 32'd0);
		write_reg(REG_CELLS_PER_M, 32'd0);
		cfg_we <= 1'b0;
		ask_point($urandom, $urandom);
		settle();
		write_reg(REG_KERNEL_SIZE, 32'd15);
		write_reg(REG_CELLS_PER_M, 32'h0001_0000);
		cfg_we <= 1'b0;
		ask_point(32'd0, 32'd0);
		settle();
		write_reg(REG_MAP_WIDTH, 32'd2);
		cfg_we <= 1'b0;
		ask_point(32'd0, 32'd0);

		scenario = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			scenario++;
			steady = ($urandom_range(0, 4) == 0);
			if (map_loaded && $urandom_range(0, 3) == 0) begin
				program_lookup();
				cfg_we <= 1'b0;
				probe_map($urandom_range(10, 25));
			end else begin
				case (scenario)
					3: begin
						w_val = 32'd1023;
						h_val = 32'd1;
					end
					6: begin
						w_val = 32'd0;
						h_val = 32'd0;
					end
					9: begin
						w_val = 32'd1;
						h_val = 32'd600;
					end
					default: begin
						w_val = $urandom_range(1, 14);
						h_val = $urandom_range(1, 14);
					end
				endcase
				write_reg(REG_MAP_WIDTH, pad_upper(w_val, 10));
				write_reg(REG_MAP_HEIGHT, pad_upper(h_val, 10));
				program_lookup();
				cfg_we <= 1'b0;
				case ($urandom_range(0, 3))
					0:       free_pct = 100;
					1:       free_pct = 97;
					2:       free_pct = 85;
					default: free_pct = 50;
				endcase
				fill_map(free_pct, $urandom_range(0, 4) == 0);
				probe_map($urandom_range(10, 30));
			end
		end

		settle();
		if (mismatches == 0 && answers_due == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
